// ----- rtl/core/abs_pkg.sv -----
`default_nettype none
package abs_pkg;
  localparam int CHANNELS = 3;
  localparam int SAMPLE_W = 8;
  localparam int SUM_W = 24;
  localparam int COUNT_W = 16;
  localparam int THR_W = 17;
  localparam int SCALE_W = 4;
  localparam int CFG_IDX_W = 2;
  localparam int PIX_W = 14;
  localparam int MASK_W = 8;
  localparam int OUT_DEPTH = 4;

  localparam int CAMERAS_DEF = 2;
  localparam int PIXELS_DEF = 16384;
  localparam int FRACTION_BITS_DEF = 4;

  localparam logic [SCALE_W-1:0] HIGH_SCALE_RST = 4'd7;
  localparam logic [SCALE_W-1:0] LOW_SCALE_RST = 4'd6;
  localparam logic [MASK_W-1:0] MASK_FG = 8'd255;
  localparam logic [MASK_W-1:0] MASK_BG = 8'd0;

  typedef enum logic [1:0] {
    OP_LEARN    = 2'd0,
    OP_BUILD    = 2'd1,
    OP_CLASSIFY = 2'd2
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HIGH_SCALE = 2'd0,
    CFG_LOW_SCALE  = 2'd1
  } cfg_reg_t;

  typedef struct packed {
    logic clear;
    logic learn;
    logic first;
    logic thr_wr;
  } lane_ctl_t;
endpackage
`default_nettype wire

// ----- rtl/core/averaging_background_subtractor.sv -----
// classify: result queued after stage 1; one item per cycle while in_stall is low
// learn and build: one item per cycle outside clearing, no result; a build writes
//   its thresholds after the divider stages (one quotient bit per divider stage)
// a classify item waits while a build is in flight
// reset: synchronous; the model stores are then zeroed one pixel per cycle over
//   all CAMERAS*PIXELS rows, with in_stall high (configuration writes still taken)
`default_nettype none
module averaging_background_subtractor #(
  parameter int CAMERAS = abs_pkg::CAMERAS_DEF,
  parameter int PIXELS = abs_pkg::PIXELS_DEF,
  parameter int FRACTION_BITS = abs_pkg::FRACTION_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      in_operation,
  input  logic                            in_camera,
  input  logic [abs_pkg::PIX_W-1:0]       in_pixel_index,
  input  logic [abs_pkg::SAMPLE_W-1:0]    in_red,
  input  logic [abs_pkg::SAMPLE_W-1:0]    in_green,
  input  logic [abs_pkg::SAMPLE_W-1:0]    in_blue,
  input  logic                            in_last_pixel,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_camera,
  output logic [abs_pkg::PIX_W-1:0]       out_pixel_index,
  output logic [abs_pkg::MASK_W-1:0]      out_mask_value,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [abs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [abs_pkg::SCALE_W-1:0]     cfg_data
);
  localparam int ROWS = CAMERAS * PIXELS;
  localparam int ADDR_W = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int NUM_W = abs_pkg::SUM_W + FRACTION_BITS;
  localparam int DIV_LAT = NUM_W + 1;
  localparam int CH = abs_pkg::CHANNELS;
  localparam int COUNT_W = abs_pkg::COUNT_W;
  localparam int OD = abs_pkg::OUT_DEPTH;
  localparam int OP_W = $clog2(OD);
  localparam int OC_W = $clog2(OD + 1);

  logic                       in_acc, in_ok, bld_busy, out_full;
  logic [ADDR_W-1:0]          in_addr;

  logic                       clearing_r;
  logic [ADDR_W-1:0]          clr_cnt_r;
  logic [abs_pkg::SCALE_W-1:0] hs_r, ls_r;

  logic                       s1_learn_r, s1_build_r, s1_cls_r;
  logic                       s1_ok_r, s1_cam_r, s1_last_r;
  logic [ADDR_W-1:0]          s1_addr_r;
  logic [abs_pkg::PIX_W-1:0]  s1_pix_r;

  logic [COUNT_W-1:0]         fc_r [CAMERAS];
  logic [COUNT_W-1:0]         fc_cur, count_n;
  logic                       first_r;

  logic                       bld_v_r [DIV_LAT];
  logic [ADDR_W-1:0]          bld_addr_r [DIV_LAT];
  logic                       m_v_r;
  logic [ADDR_W-1:0]          m_addr_r;
  logic                       any_bld;

  abs_pkg::lane_ctl_t         ctl;
  logic [abs_pkg::SAMPLE_W-1:0] samples [CH];
  logic [CH-1:0]              hits;

  logic                       fifo_cam_r [OD];
  logic [abs_pkg::PIX_W-1:0]  fifo_pix_r [OD];
  logic [abs_pkg::MASK_W-1:0] fifo_mask_r [OD];
  logic [OP_W-1:0]            wp_r, rp_r;
  logic [OC_W-1:0]            cnt_r;
  logic                       pop;

  // input side
  assign in_ok   = (int'(in_camera) < CAMERAS) && (int'(in_pixel_index) < PIXELS);
  assign in_addr = ADDR_W'(int'(in_camera) * PIXELS + int'(in_pixel_index));
  assign out_full = (OC_W'(cnt_r) + OC_W'(s1_cls_r)) >= OC_W'(OD - 1);
  assign in_stall = clearing_r ||
                    ((in_operation == abs_pkg::OP_CLASSIFY) && (bld_busy || out_full));
  assign in_acc  = in_valid && !in_stall;

  always_comb begin
    any_bld = 1'b0;
    for (int i = 0; i < DIV_LAT; i++) begin
      any_bld = any_bld | bld_v_r[i];
    end
  end
  assign bld_busy = s1_build_r || any_bld || m_v_r;

  // configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hs_r <= abs_pkg::HIGH_SCALE_RST;
      ls_r <= abs_pkg::LOW_SCALE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        abs_pkg::CFG_HIGH_SCALE: hs_r <= cfg_data;
        abs_pkg::CFG_LOW_SCALE:  ls_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // store clearing sweep
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else if (clearing_r) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
      if (clr_cnt_r == ADDR_W'(ROWS - 1)) begin
        clearing_r <= 1'b0;
      end
    end
  end

  // stage 1
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_learn_r <= 1'b0;
      s1_build_r <= 1'b0;
      s1_cls_r   <= 1'b0;
    end else begin
      s1_learn_r <= in_acc && (in_operation == abs_pkg::OP_LEARN) && in_ok;
      s1_build_r <= in_acc && (in_operation == abs_pkg::OP_BUILD) && in_ok;
      s1_cls_r   <= in_acc && (in_operation == abs_pkg::OP_CLASSIFY);
    end
    s1_ok_r   <= in_ok;
    s1_cam_r  <= in_camera;
    s1_last_r <= in_last_pixel;
    s1_addr_r <= in_addr;
    s1_pix_r  <= in_pixel_index;
  end

  // frame counts
  assign fc_cur  = fc_r[s1_cam_r];
  assign count_n = (fc_cur == '0) ? COUNT_W'(1) : fc_cur;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r <= 1'b1;
      for (int i = 0; i < CAMERAS; i++) begin
        fc_r[i] <= '0;
      end
    end else if (s1_learn_r && s1_last_r) begin
      first_r <= 1'b0;
      for (int i = 0; i < CAMERAS; i++) begin
        if (!first_r && (int'(s1_cam_r) == i) && (fc_r[i] != '1)) begin
          fc_r[i] <= fc_r[i] + 1'b1;
        end
      end
    end
  end

  // build tags follow the divider stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DIV_LAT; i++) begin
        bld_v_r[i] <= 1'b0;
      end
      m_v_r <= 1'b0;
    end else begin
      bld_v_r[0] <= s1_build_r;
      for (int i = 1; i < DIV_LAT; i++) begin
        bld_v_r[i] <= bld_v_r[i-1];
      end
      m_v_r <= bld_v_r[DIV_LAT-1];
    end
    bld_addr_r[0] <= s1_addr_r;
    for (int i = 1; i < DIV_LAT; i++) begin
      bld_addr_r[i] <= bld_addr_r[i-1];
    end
    m_addr_r <= bld_addr_r[DIV_LAT-1];
  end

  // channel lanes
  assign ctl.clear  = clearing_r;
  assign ctl.learn  = s1_learn_r;
  assign ctl.first  = first_r;
  assign ctl.thr_wr = m_v_r;

  assign samples[0] = in_red;
  assign samples[1] = in_green;
  assign samples[2] = in_blue;

  for (genvar c = 0; c < CH; c++) begin : g_lane
    abs_lane #(
      .ADDR_W(ADDR_W), .ROWS(ROWS), .FRACTION_BITS(FRACTION_BITS)
    ) u_lane (
      .clk(clk), .rst_n(rst_n), .ctl(ctl), .clr_addr(clr_cnt_r),
      .rd_addr(in_addr), .s1_addr(s1_addr_r), .thr_addr(m_addr_r),
      .sample(samples[c]), .count_n(count_n), .high_scale(hs_r),
      .low_scale(ls_r), .in_range(hits[c])
    );
  end

  // merge and result queue
  assign pop = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (s1_cls_r) begin
        wp_r <= wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= rp_r + 1'b1;
      end
      cnt_r <= cnt_r + OC_W'(s1_cls_r) - OC_W'(pop);
    end
    if (s1_cls_r) begin
      fifo_cam_r[wp_r]  <= s1_cam_r;
      fifo_pix_r[wp_r]  <= s1_pix_r;
      fifo_mask_r[wp_r] <= (s1_ok_r && (|hits)) ? abs_pkg::MASK_BG : abs_pkg::MASK_FG;
    end
  end

  assign out_valid       = cnt_r != '0;
  assign out_camera      = fifo_cam_r[rp_r];
  assign out_pixel_index = fifo_pix_r[rp_r];
  assign out_mask_value  = fifo_mask_r[rp_r];

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(cnt_r) <= OD)
    else $error("result queue overflow");

  a_cls_after_build: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_operation == abs_pkg::OP_CLASSIFY)) |-> !bld_busy)
    else $error("classify item taken with a build in flight");

  a_no_item_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clearing_r |-> !in_acc)
    else $error("item taken during store clearing");

  a_no_thr_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (m_v_r || s1_learn_r) |-> !clearing_r)
    else $error("store write collides with clearing");
endmodule
`default_nettype wire

// ----- rtl/core/abs_ram.sv -----
`default_nettype none
module abs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata_r
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- rtl/core/abs_divider.sv -----
`default_nettype none
module abs_divider #(
  parameter int NUM_W = 28,
  parameter int DEN_W = 16
) (
  input  logic             clk,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [NUM_W-1:0] quot
);
  logic [DEN_W-1:0] rem_r [NUM_W+1];
  logic [NUM_W-1:0] num_r [NUM_W+1];
  logic [NUM_W-1:0] quo_r [NUM_W+1];
  logic [DEN_W-1:0] den_r [NUM_W+1];

  always_ff @(posedge clk) begin
    rem_r[0] <= '0;
    num_r[0] <= num;
    quo_r[0] <= '0;
    den_r[0] <= den;
  end

  for (genvar k = 0; k < NUM_W; k++) begin : g_step
    logic [DEN_W:0] trial;
    logic           take;
    assign trial = {rem_r[k], num_r[k][NUM_W-1]};
    assign take  = trial >= {1'b0, den_r[k]};
    always_ff @(posedge clk) begin
      rem_r[k+1] <= take ? DEN_W'(trial - {1'b0, den_r[k]}) : trial[DEN_W-1:0];
      num_r[k+1] <= num_r[k] << 1;
      quo_r[k+1] <= {quo_r[k][NUM_W-2:0], take};
      den_r[k+1] <= den_r[k];
    end
  end

  assign quot = quo_r[NUM_W];
endmodule
`default_nettype wire

// ----- rtl/core/abs_lane.sv -----
`default_nettype none
module abs_lane #(
  parameter int ADDR_W = 15,
  parameter int ROWS = 32768,
  parameter int FRACTION_BITS = 4
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  abs_pkg::lane_ctl_t                  ctl,
  input  logic [ADDR_W-1:0]                   clr_addr,
  input  logic [ADDR_W-1:0]                   rd_addr,
  input  logic [ADDR_W-1:0]                   s1_addr,
  input  logic [ADDR_W-1:0]                   thr_addr,
  input  logic [abs_pkg::SAMPLE_W-1:0]        sample,
  input  logic [abs_pkg::COUNT_W-1:0]         count_n,
  input  logic [abs_pkg::SCALE_W-1:0]         high_scale,
  input  logic [abs_pkg::SCALE_W-1:0]         low_scale,
  output logic                                in_range
);
  localparam int SUM_W = abs_pkg::SUM_W;
  localparam int SAMPLE_W = abs_pkg::SAMPLE_W;
  localparam int THR_W = abs_pkg::THR_W;
  localparam int NUM_W = SUM_W + FRACTION_BITS;
  localparam int DIF_W = NUM_W + 1;
  localparam int PROD_W = DIF_W + abs_pkg::SCALE_W;
  localparam int EXT_W = PROD_W + 2;
  localparam int THR_MAX = 2 ** (THR_W - 1) - 1;
  localparam logic signed [EXT_W-1:0] LO_MAX = EXT_W'(THR_MAX);
  localparam logic signed [EXT_W-1:0] LO_MIN = EXT_W'(-(2 ** (THR_W - 1)));

  logic [SAMPLE_W-1:0] x_r;
  logic [SUM_W-1:0]    sum_rd, diff_rd;
  logic [SAMPLE_W-1:0] prev_rd;
  logic [THR_W-1:0]    high_rd, low_rd;

  logic                fw_v_r;
  logic [ADDR_W-1:0]   fw_addr_r;
  logic [SUM_W-1:0]    fw_sum_r, fw_diff_r;
  logic [SAMPLE_W-1:0] fw_prev_r;

  logic                hit;
  logic [SUM_W-1:0]    sum_cur, diff_cur, sum_new, diff_new, sum_wr, diff_wr;
  logic [SAMPLE_W-1:0] prev_cur, absd;
  logic [SUM_W:0]      sum_add, diff_add;

  logic                we_acc, we_thr;
  logic [ADDR_W-1:0]   acc_waddr, thr_waddr;
  logic [SUM_W-1:0]    sum_wdata, diff_wdata;
  logic [SAMPLE_W-1:0] prev_wdata;
  logic [THR_W-1:0]    high_wdata, low_wdata;

  logic [NUM_W-1:0]    num_avg, num_dif, quot_avg, quot_dif;
  logic [DIF_W-1:0]    dif;
  logic [PROD_W-1:0]   prod_h, prod_l;
  logic [NUM_W-1:0]    avg_m_r;
  logic [PROD_W-1:0]   prod_h_m_r, prod_l_m_r;
  logic [EXT_W-1:0]    hi_sum;
  logic signed [EXT_W-1:0] lo_ext;
  logic [THR_W-1:0]    hi_val, lo_val;
  logic signed [THR_W-1:0] xv;

  always_ff @(posedge clk) begin
    x_r <= sample;
  end

  // one-deep bypass: the previous learn write lands as this read is taken
  assign hit      = fw_v_r && (fw_addr_r == s1_addr);
  assign sum_cur  = hit ? fw_sum_r  : sum_rd;
  assign diff_cur = hit ? fw_diff_r : diff_rd;
  assign prev_cur = hit ? fw_prev_r : prev_rd;

  assign absd     = (x_r > prev_cur) ? (x_r - prev_cur) : (prev_cur - x_r);
  assign sum_add  = {1'b0, sum_cur} + (SUM_W+1)'(x_r);
  assign diff_add = {1'b0, diff_cur} + (SUM_W+1)'(absd);
  assign sum_new  = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
  assign diff_new = diff_add[SUM_W] ? '1 : diff_add[SUM_W-1:0];
  assign sum_wr   = ctl.first ? sum_cur : sum_new;
  assign diff_wr  = ctl.first ? diff_cur : diff_new;

  assign we_acc     = ctl.clear || ctl.learn;
  assign acc_waddr  = ctl.clear ? clr_addr : s1_addr;
  assign sum_wdata  = ctl.clear ? '0 : sum_wr;
  assign diff_wdata = ctl.clear ? '0 : diff_wr;
  assign prev_wdata = ctl.clear ? '0 : x_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_v_r <= 1'b0;
    end else begin
      fw_v_r <= ctl.learn;
    end
    fw_addr_r <= s1_addr;
    fw_sum_r  <= sum_wr;
    fw_diff_r <= diff_wr;
    fw_prev_r <= x_r;
  end

  abs_ram #(.WIDTH(SUM_W), .DEPTH(ROWS)) u_sum_ram (
    .clk(clk), .we(we_acc), .waddr(acc_waddr), .wdata(sum_wdata),
    .raddr(rd_addr), .rdata_r(sum_rd)
  );
  abs_ram #(.WIDTH(SUM_W), .DEPTH(ROWS)) u_diff_ram (
    .clk(clk), .we(we_acc), .waddr(acc_waddr), .wdata(diff_wdata),
    .raddr(rd_addr), .rdata_r(diff_rd)
  );
  abs_ram #(.WIDTH(SAMPLE_W), .DEPTH(ROWS)) u_prev_ram (
    .clk(clk), .we(we_acc), .waddr(acc_waddr), .wdata(prev_wdata),
    .raddr(rd_addr), .rdata_r(prev_rd)
  );

  // threshold build
  assign num_avg = NUM_W'(sum_cur) << FRACTION_BITS;
  assign num_dif = NUM_W'(diff_cur) << FRACTION_BITS;

  abs_divider #(.NUM_W(NUM_W), .DEN_W(abs_pkg::COUNT_W)) u_div_avg (
    .clk(clk), .num(num_avg), .den(count_n), .quot(quot_avg)
  );
  abs_divider #(.NUM_W(NUM_W), .DEN_W(abs_pkg::COUNT_W)) u_div_dif (
    .clk(clk), .num(num_dif), .den(count_n), .quot(quot_dif)
  );

  assign dif    = DIF_W'(quot_dif) + (DIF_W'(1) << FRACTION_BITS);
  assign prod_h = high_scale * dif;
  assign prod_l = low_scale * dif;

  always_ff @(posedge clk) begin
    avg_m_r    <= quot_avg;
    prod_h_m_r <= prod_h;
    prod_l_m_r <= prod_l;
  end

  assign hi_sum = EXT_W'(avg_m_r) + EXT_W'(prod_h_m_r);
  assign lo_ext = $signed(EXT_W'(avg_m_r)) - $signed(EXT_W'(prod_l_m_r));
  assign hi_val = (hi_sum > EXT_W'(THR_MAX)) ? THR_W'(THR_MAX) : hi_sum[THR_W-1:0];
  always_comb begin
    if (lo_ext > LO_MAX) begin
      lo_val = LO_MAX[THR_W-1:0];
    end else if (lo_ext < LO_MIN) begin
      lo_val = LO_MIN[THR_W-1:0];
    end else begin
      lo_val = lo_ext[THR_W-1:0];
    end
  end

  assign we_thr     = ctl.clear || ctl.thr_wr;
  assign thr_waddr  = ctl.clear ? clr_addr : thr_addr;
  assign high_wdata = ctl.clear ? '0 : hi_val;
  assign low_wdata  = ctl.clear ? '0 : lo_val;

  abs_ram #(.WIDTH(THR_W), .DEPTH(ROWS)) u_high_ram (
    .clk(clk), .we(we_thr), .waddr(thr_waddr), .wdata(high_wdata),
    .raddr(rd_addr), .rdata_r(high_rd)
  );
  abs_ram #(.WIDTH(THR_W), .DEPTH(ROWS)) u_low_ram (
    .clk(clk), .we(we_thr), .waddr(thr_waddr), .wdata(low_wdata),
    .raddr(rd_addr), .rdata_r(low_rd)
  );

  // classify test
  assign xv       = $signed(THR_W'(THR_W'(x_r) << FRACTION_BITS));
  assign in_range = ($signed(low_rd) <= xv) && (xv < $signed(high_rd));
endmodule
`default_nettype wire

// ----- tb/background_model_checker.sv -----
`default_nettype none
module background_model_checker (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  input  wire logic                          in_stall,
  input  wire logic [1:0]                    in_operation,
  input  wire logic                          in_camera,
  input  wire logic [abs_pkg::PIX_W-1:0]     in_pixel_index,
  input  wire logic [abs_pkg::SAMPLE_W-1:0]  in_red,
  input  wire logic [abs_pkg::SAMPLE_W-1:0]  in_green,
  input  wire logic [abs_pkg::SAMPLE_W-1:0]  in_blue,
  input  wire logic                          in_last_pixel,
  input  wire logic                          out_valid,
  input  wire logic                          out_stall,
  input  wire logic                          out_camera,
  input  wire logic [abs_pkg::PIX_W-1:0]     out_pixel_index,
  input  wire logic [abs_pkg::MASK_W-1:0]    out_mask_value,
  input  wire logic                          cfg_valid,
  input  wire logic                          cfg_ready,
  input  wire logic [abs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [abs_pkg::SCALE_W-1:0]   cfg_data,
  output int                                 errors,
  output int                                 pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import abs_pkg::*;

  localparam int NPIX = PIXELS_DEF;
  localparam int FB = FRACTION_BITS_DEF;
  localparam int SUM_MAX = (1 << SUM_W) - 1;
  localparam int COUNT_MAX = (1 << COUNT_W) - 1;

  typedef struct {
    logic               camera;
    logic [PIX_W-1:0]   pixel;
    logic [MASK_W-1:0]  mask;
  } mask_item_t;

  mask_item_t mask_q[$];

  bit [SUM_W-1:0]    sum_acc[int];
  bit [SUM_W-1:0]    diff_acc[int];
  bit [SAMPLE_W-1:0] prev_px[int];
  int                high_thr[int];
  int                low_thr[int];
  int                frames[2];
  bit                first_frame;
  int                high_scale;
  int                low_scale;

  function automatic int slot(logic cam, logic [PIX_W-1:0] pix, int c);
    return (int'(cam) * NPIX + int'(pix)) * CHANNELS + c;
  endfunction

  function automatic int clamp_thr(longint v);
    if (v > 65535) return 65535;
    if (v < -65536) return -65536;
    return int'(v);
  endfunction

  function automatic bit [SUM_W-1:0] sat_sum(bit [SUM_W-1:0] a, int b);
    int s;
    s = int'(a) + b;
    return (s > SUM_MAX) ? SUM_W'(SUM_MAX) : SUM_W'(s);
  endfunction

  task automatic apply_pixel(logic [1:0] op, logic cam, logic [PIX_W-1:0] pix,
                             logic [SAMPLE_W-1:0] r, logic [SAMPLE_W-1:0] g,
                             logic [SAMPLE_W-1:0] b, logic last);
    int x[3];
    int k;
    int p;
    int n;
    longint avg;
    longint dif;
    bit any;
    mask_item_t m;
    x[0] = r;
    x[1] = g;
    x[2] = b;
    if (op == OP_LEARN) begin
      for (int c = 0; c < CHANNELS; c++) begin
        k = slot(cam, pix, c);
        if (!first_frame) begin
          p = prev_px.exists(k) ? int'(prev_px[k]) : 0;
          sum_acc[k] = sat_sum(sum_acc.exists(k) ? sum_acc[k] : '0, x[c]);
          diff_acc[k] = sat_sum(diff_acc.exists(k) ? diff_acc[k] : '0,
                                (x[c] > p) ? x[c] - p : p - x[c]);
        end
        prev_px[k] = SAMPLE_W'(x[c]);
      end
      if (last) begin
        if (!first_frame && frames[cam] < COUNT_MAX) frames[cam]++;
        first_frame = 0;
      end
    end else if (op == OP_BUILD) begin
      n = (frames[cam] != 0) ? frames[cam] : 1;
      for (int c = 0; c < CHANNELS; c++) begin
        k = slot(cam, pix, c);
        avg = (longint'(sum_acc.exists(k) ? sum_acc[k] : '0) << FB) / n;
        dif = ((longint'(diff_acc.exists(k) ? diff_acc[k] : '0) << FB) / n) + (1 << FB);
        high_thr[k] = clamp_thr(avg + longint'(high_scale) * dif);
        low_thr[k] = clamp_thr(avg - longint'(low_scale) * dif);
      end
    end else if (op == OP_CLASSIFY) begin
      any = 0;
      for (int c = 0; c < CHANNELS; c++) begin
        k = slot(cam, pix, c);
        if ((low_thr.exists(k) ? low_thr[k] : 0) <= (x[c] << FB) &&
            (x[c] << FB) < (high_thr.exists(k) ? high_thr[k] : 0)) any = 1;
      end
      m.camera = cam;
      m.pixel = pix;
      m.mask = any ? MASK_BG : MASK_FG;
      mask_q.push_back(m);
    end
  endtask

  always @(posedge clk) begin
    mask_item_t e;
    if (!rst_n) begin
      sum_acc.delete();
      diff_acc.delete();
      prev_px.delete();
      high_thr.delete();
      low_thr.delete();
      frames[0] = 0;
      frames[1] = 0;
      first_frame = 1;
      high_scale = HIGH_SCALE_RST;
      low_scale = LOW_SCALE_RST;
      mask_q.delete();
      errors = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_HIGH_SCALE) high_scale = cfg_data;
        else if (cfg_index == CFG_LOW_SCALE) low_scale = cfg_data;
      end
      if (out_valid && !out_stall) begin
        if (mask_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected result cam=%0d pix=%0d mask=%0d",
                     out_camera, out_pixel_index, out_mask_value);
        end else begin
          e = mask_q.pop_front();
          if (e.camera !== out_camera || e.pixel !== out_pixel_index ||
              e.mask !== out_mask_value) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: expected cam=%0d pix=%0d mask=%0d, got %0d %0d %0d",
                       e.camera, e.pixel, e.mask,
                       out_camera, out_pixel_index, out_mask_value);
          end
        end
      end
      if (in_valid && !in_stall)
        apply_pixel(in_operation, in_camera, in_pixel_index, in_red, in_green,
                    in_blue, in_last_pixel);
    end
    pending = mask_q.size();
  end
endmodule
`default_nettype wire

// ----- tb/tb.sv -----
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import abs_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int SETTLE = SUM_W + FRACTION_BITS_DEF + 12;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  logic [1:0] in_operation = OP_LEARN;
  logic in_camera = 0;
  logic [PIX_W-1:0] in_pixel_index = '0;
  logic [SAMPLE_W-1:0] in_red = '0;
  logic [SAMPLE_W-1:0] in_green = '0;
  logic [SAMPLE_W-1:0] in_blue = '0;
  logic in_last_pixel = 0;
  logic out_valid;
  logic out_stall = 0;
  logic out_camera;
  logic [PIX_W-1:0] out_pixel_index;
  logic [MASK_W-1:0] out_mask_value;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_HIGH_SCALE;
  logic [SCALE_W-1:0] cfg_data = '0;
  int errors;
  int pending;
  int burst_left = 0;
  bit hold_req = 0;
  logic [PIX_W-1:0] pool[8];
  logic [SAMPLE_W-1:0] shade[8][3];

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  averaging_background_subtractor u_top (.*);

  background_model_checker u_checker (.*);

  // receiver stall pattern with occasional long hold
  initial begin
    int hold;
    int mode;
    int left;
    hold = 0;
    mode = 0;
    left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 0;
        hold = 400;
      end
      if (left == 0) begin
        mode = $urandom_range(0, 2);
        left = $urandom_range(20, 120);
      end
      left--;
      if (hold > 0) begin
        hold--;
        out_stall <= 1;
      end else if (mode == 0) out_stall <= 0;
      else if (mode == 1) out_stall <= ($urandom_range(0, 3) == 0);
      else out_stall <= ($urandom_range(0, 3) != 0);
    end
  end

  task automatic push_pixel(logic [1:0] op, logic cam, logic [PIX_W-1:0] pix,
                            logic [SAMPLE_W-1:0] r, logic [SAMPLE_W-1:0] g,
                            logic [SAMPLE_W-1:0] b, logic last);
    if (burst_left == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200)
                                               : $urandom_range(1, 16);
    end
    in_valid <= 1;
    in_operation <= op;
    in_camera <= cam;
    in_pixel_index <= pix;
    in_red <= r;
    in_green <= g;
    in_blue <= b;
    in_last_pixel <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
  endtask

  task automatic drain;
    in_valid <= 0;
    burst_left = 0;
    @(posedge clk);
    wait (pending == 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_scale(cfg_reg_t idx, logic [SCALE_W-1:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  function automatic logic [SAMPLE_W-1:0] near(logic [SAMPLE_W-1:0] base);
    int v;
    v = int'(base) + $urandom_range(0, 16) - 8;
    if ($urandom_range(0, 7) == 0) v = $urandom_range(0, 255);
    return (v < 0) ? 8'd0 : (v > 255) ? 8'd255 : SAMPLE_W'(v);
  endfunction

  task automatic run_phase(int mixed, bit with_hold);
    int p;
    logic cam;
    pool[0] = '0;
    pool[1] = '1;
    for (int i = 2; i < 8; i++) pool[i] = $urandom_range(0, 16383);
    for (int i = 0; i < 8; i++)
      for (int c = 0; c < 3; c++) shade[i][c] = $urandom_range(0, 255);
    for (int f = 0; f < 4; f++)
      for (int cm = 0; cm < 2; cm++)
        for (int i = 0; i < 8; i++)
          push_pixel(OP_LEARN, cm[0], pool[i], near(shade[i][0]), near(shade[i][1]),
                     near(shade[i][2]), i == 7);
    for (int cm = 0; cm < 2; cm++)
      for (int i = 0; i < 8; i++)
        push_pixel(OP_BUILD, cm[0], pool[i], '0, '0, '0, 0);
    if (with_hold) begin
      hold_req = 1;
      for (int i = 0; i < 60; i++) begin
        p = $urandom_range(0, 7);
        push_pixel(OP_CLASSIFY, $urandom_range(0, 1), pool[p], near(shade[p][0]),
                   near(shade[p][1]), near(shade[p][2]), 0);
      end
    end
    for (int i = 0; i < mixed; i++) begin
      p = $urandom_range(0, 7);
      cam = $urandom_range(0, 1);
      case ($urandom_range(0, 19))
        0, 1, 2, 3: push_pixel(OP_LEARN, cam, pool[p], near(shade[p][0]),
                               near(shade[p][1]), near(shade[p][2]),
                               $urandom_range(0, 7) == 0);
        4, 5: push_pixel(OP_BUILD, cam, pool[p], $urandom, $urandom, $urandom,
                         $urandom_range(0, 1));
        6: push_pixel(OP_UNUSED, cam, $urandom, $urandom, $urandom, $urandom,
                      $urandom_range(0, 1));
        7: push_pixel(OP_CLASSIFY, cam, $urandom, $urandom, $urandom, $urandom,
                      $urandom_range(0, 1));
        default: push_pixel(OP_CLASSIFY, cam, pool[p], near(shade[p][0]),
                            near(shade[p][1]), near(shade[p][2]),
                            $urandom_range(0, 1));
      endcase
    end
    drain();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // first frame, never-built thresholds, empty counts, extremes
    push_pixel(OP_CLASSIFY, 0, '0, '0, '0, '0, 0);
    push_pixel(OP_LEARN, 0, '0, '0, '0, '0, 0);
    push_pixel(OP_LEARN, 1, '1, '1, '1, '1, 1);
    push_pixel(OP_BUILD, 1, '1, '0, '0, '0, 0);
    push_pixel(OP_CLASSIFY, 1, '1, '0, '0, '0, 0);
    push_pixel(OP_CLASSIFY, 1, '1, 8'd1, 8'd255, 8'd16, 1);
    push_pixel(OP_LEARN, 0, '0, '1, '1, '1, 0);
    push_pixel(OP_LEARN, 1, '1, '0, '0, '0, 1);
    push_pixel(OP_LEARN, 0, '0, '0, 8'd128, '1, 1);
    push_pixel(OP_UNUSED, 1, '1, '1, '1, '1, 1);
    push_pixel(OP_BUILD, 0, '0, '1, '1, '1, 1);
    push_pixel(OP_BUILD, 1, '1, '0, '0, '0, 0);
    push_pixel(OP_BUILD, 0, 14'd77, '0, '0, '0, 0);
    push_pixel(OP_CLASSIFY, 0, '0, '0, '0, '0, 0);
    push_pixel(OP_CLASSIFY, 0, '0, '1, '1, '1, 0);
    push_pixel(OP_CLASSIFY, 0, '0, 8'd128, 8'd64, 8'd200, 0);
    push_pixel(OP_CLASSIFY, 1, '1, '1, '1, '1, 1);
    push_pixel(OP_CLASSIFY, 0, 14'd77, '0, '0, '0, 0);
    push_pixel(OP_CLASSIFY, 1, 14'h2AAA, 8'h55, 8'hAA, 8'h0F, 0);
    drain();
    run_phase(110, 1);
    write_scale(CFG_HIGH_SCALE, 4'd0);
    write_scale(CFG_LOW_SCALE, 4'd0);
    run_phase(110, 0);
    write_scale(CFG_HIGH_SCALE, 4'd15);
    write_scale(CFG_LOW_SCALE, 4'd15);
    run_phase(110, 0);
    write_scale(CFG_HIGH_SCALE, 4'd15);
    write_scale(CFG_LOW_SCALE, 4'd0);
    run_phase(110, 1);
    write_scale(CFG_HIGH_SCALE, $urandom_range(0, 15));
    write_scale(CFG_LOW_SCALE, $urandom_range(0, 15));
    run_phase(110, 0);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("CHECKS FAILED");
    $finish;
  end
endmodule
`default_nettype wire
